/* design/ptrs_pkg.sv */
// Package for the point table radius search block.
// Shared types, codes, widths and the name canonicalization function.
// No dependencies.
`default_nettype none
package ptrs_pkg;

  localparam int unsigned TableDepthDef = 32;
  localparam int unsigned NameW = 192;
  localparam int unsigned CoordW = 16;
  localparam int unsigned RadiusW = 17;
  localparam int unsigned EntryW = NameW + 2 * CoordW;
  localparam int unsigned InDataW = 248;
  localparam int unsigned SqW = 2 * (CoordW + 1);

  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_DEL_NAME  = 3'd1,
    CMD_DEL_POINT = 3'd2,
    CMD_FIND_NAME = 3'd3,
    CMD_FIND_PT   = 3'd4,
    CMD_AROUND_NM = 3'd5,
    CMD_AROUND_PT = 3'd6,
    CMD_LIST      = 3'd7
  } ptrs_cmd_e;

  typedef enum logic [1:0] {
    ST_RECORD    = 2'd0,
    ST_DONE      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } ptrs_status_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_INS,
    FSM_SCAN_RD,
    FSM_SCAN_CMP,
    FSM_SHIFT_RD,
    FSM_SHIFT_WR,
    FSM_NB_RD,
    FSM_NB_SQ,
    FSM_NB_CMP,
    FSM_FINISH
  } ptrs_fsm_e;

  // One result handed to the output register
  typedef struct packed {
    logic              valid;
    logic              last;
    ptrs_status_e      status;
    logic [EntryW-1:0] entry;
  } ptrs_push_t;

  // Clear every byte after the first zero byte; words laid out {low, mid, high}
  function automatic logic [NameW-1:0] canon_name(input logic [63:0] hi,
                                                  input logic [63:0] mid,
                                                  input logic [63:0] lo);
    logic [NameW-1:0] src;
    logic [NameW-1:0] res;
    logic             ended;
    logic [7:0]       bt;
    src   = {hi, mid, lo};
    res   = '0;
    ended = 1'b0;
    for (int b = 0; b < 24; b++) begin
      bt = src[NameW-1-8*b -: 8];
      if (bt == 8'd0) ended = 1'b1;
      if (!ended) res[NameW-1-8*b -: 8] = bt;
    end
    return {res[63:0], res[127:64], res[191:128]};
  endfunction

endpackage
`default_nettype wire

/* design/ptrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ptrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* design/ptrs_sq.sv */
// Distance unit: registered squares of the offsets from the search center.
// Depends on ptrs_pkg.
`default_nettype none
module ptrs_sq (
  input  wire logic                              clk_i,
  input  wire logic signed [ptrs_pkg::CoordW-1:0] x_i,
  input  wire logic signed [ptrs_pkg::CoordW-1:0] y_i,
  input  wire logic signed [ptrs_pkg::CoordW-1:0] cx_i,
  input  wire logic signed [ptrs_pkg::CoordW-1:0] cy_i,
  output logic             [ptrs_pkg::SqW:0]      dist_o
);
  import ptrs_pkg::*;

  logic signed [CoordW:0] dx, dy;
  logic signed [SqW-1:0]  dxsq_q, dysq_q;

  assign dx = {x_i[CoordW-1], x_i} - {cx_i[CoordW-1], cx_i};
  assign dy = {y_i[CoordW-1], y_i} - {cy_i[CoordW-1], cy_i};

  always_ff @(posedge clk_i) begin
    dxsq_q <= dx * dx;
    dysq_q <= dy * dy;
  end

  // squares are never negative
  assign dist_o = {1'b0, dxsq_q} + {1'b0, dysq_q};

endmodule
`default_nettype wire

/* design/ptrs_ctrl.sv */
// Command sequencer: scans the table memory, shifts on delete, runs the
// neighbor pass. Depends on ptrs_pkg, ptrs_ram, ptrs_sq.
`default_nettype none
module ptrs_ctrl #(
  parameter int unsigned TableDepth = ptrs_pkg::TableDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  output logic                               req_ready_o,
  input  wire logic [2:0]                    req_cmd_i,
  input  wire logic [ptrs_pkg::InDataW-1:0]  req_data_i,
  input  wire logic                          can_push_i,
  output ptrs_pkg::ptrs_push_t               push_o
);
  import ptrs_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);

  ptrs_fsm_e state_q, state_d;
  ptrs_cmd_e cmd_q, cmd_d;
  ptrs_status_e fin_q, fin_d;
  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d, ci_q, ci_d;
  logic [EntryW-1:0] key_q, key_d, pend_q, pend_d;
  logic pend_v_q, pend_v_d;
  logic signed [CoordW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [SqW-1:0] rr_q, rr_d;
  logic rneg_q, rneg_d;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [SqW:0]      dsum;
  logic              name_eq, pt_eq, hit, last_idx;
  logic signed [RadiusW-1:0] r_in;

  ptrs_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  ptrs_sq u_sq (
    .clk_i, .x_i(rdata[NameW +: CoordW]), .y_i(rdata[NameW+CoordW +: CoordW]),
    .cx_i(cx_q), .cy_i(cy_q), .dist_o(dsum)
  );

  assign name_eq  = rdata[NameW-1:0] == key_q[NameW-1:0];
  assign pt_eq    = rdata[EntryW-1:NameW] == key_q[EntryW-1:NameW];
  assign last_idx = (idx_q + 1'b1) == cnt_q;
  assign r_in     = req_data_i[EntryW +: RadiusW];
  assign req_ready_o = state_q == FSM_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    fin_q  <= fin_d;
    idx_q  <= idx_d;
    ci_q   <= ci_d;
    key_q  <= key_d;
    pend_q <= pend_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    rr_q   <= rr_d;
    rneg_q <= rneg_d;
  end

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; fin_d = fin_q; cnt_d = cnt_q;
    idx_d = idx_q; ci_d = ci_q; key_d = key_q; pend_d = pend_q;
    pend_v_d = pend_v_q; cx_d = cx_q; cy_d = cy_q; rr_d = rr_q; rneg_d = rneg_q;
    we = 1'b0; waddr = idx_q[AddrW-1:0]; wdata = rdata;
    raddr = idx_q[AddrW-1:0];
    push_o = '{valid: 1'b0, last: 1'b0, status: ST_RECORD, entry: pend_q};
    hit = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        if (req_valid_i) begin
          cmd_d  = ptrs_cmd_e'(req_cmd_i);
          key_d  = {req_data_i[EntryW-1:NameW],
                    canon_name(req_data_i[63:0], req_data_i[127:64],
                               req_data_i[191:128])};
          rr_d   = SqW'(r_in * r_in);
          rneg_d = r_in[RadiusW-1];
          idx_d  = '0;
          pend_v_d = 1'b0;
          if (ptrs_cmd_e'(req_cmd_i) == CMD_INSERT) begin
            if (cnt_q == CntW'(TableDepth)) begin
              fin_d = ST_FULL; state_d = FSM_FINISH;
            end else begin
              state_d = FSM_INS;
            end
          end else if (cnt_q == '0) begin
            fin_d = ST_NOT_FOUND; state_d = FSM_FINISH;
          end else begin
            state_d = FSM_SCAN_RD;
          end
        end
      end
      FSM_INS: begin
        we = 1'b1; waddr = cnt_q[AddrW-1:0]; wdata = key_q;
        cnt_d = cnt_q + 1'b1;
        fin_d = ST_DONE; state_d = FSM_FINISH;
      end
      FSM_SCAN_RD: state_d = FSM_SCAN_CMP;
      FSM_SCAN_CMP: begin
        case (cmd_q)
          CMD_LIST: hit = 1'b1;
          CMD_DEL_NAME, CMD_FIND_NAME, CMD_AROUND_NM: hit = name_eq;
          default: hit = pt_eq;
        endcase
        if (hit && (cmd_q inside {CMD_DEL_NAME, CMD_DEL_POINT})) begin
          if (last_idx) begin
            cnt_d = cnt_q - 1'b1; fin_d = ST_DONE; state_d = FSM_FINISH;
          end else begin
            state_d = FSM_SHIFT_RD;
          end
        end else if (hit && (cmd_q inside {CMD_AROUND_NM, CMD_AROUND_PT})) begin
          ci_d = idx_q; idx_d = '0;
          if (cmd_q == CMD_AROUND_NM) begin
            cx_d = rdata[NameW +: CoordW];
            cy_d = rdata[NameW+CoordW +: CoordW];
          end else begin
            cx_d = key_q[NameW +: CoordW];
            cy_d = key_q[NameW+CoordW +: CoordW];
          end
          fin_d = ST_DONE;
          state_d = rneg_q ? FSM_FINISH : FSM_NB_RD;
        end else if (hit && pend_v_q && !can_push_i) begin
          state_d = FSM_SCAN_CMP;
        end else begin
          if (hit) begin
            push_o.valid = pend_v_q;
            pend_d = rdata; pend_v_d = 1'b1;
          end
          if (last_idx) begin
            fin_d = ST_NOT_FOUND; state_d = FSM_FINISH;
          end else begin
            idx_d = idx_q + 1'b1; state_d = FSM_SCAN_RD;
          end
        end
      end
      FSM_SHIFT_RD: begin
        raddr = AddrW'(idx_q + 1'b1);
        state_d = FSM_SHIFT_WR;
      end
      FSM_SHIFT_WR: begin
        raddr = AddrW'(idx_q + 1'b1);
        we = 1'b1;
        if (CntW'(idx_q + 2'd2) == cnt_q) begin
          cnt_d = cnt_q - 1'b1; fin_d = ST_DONE; state_d = FSM_FINISH;
        end else begin
          idx_d = idx_q + 1'b1; state_d = FSM_SHIFT_RD;
        end
      end
      FSM_NB_RD: begin
        if (idx_q == ci_q) begin
          if (last_idx) state_d = FSM_FINISH;
          else idx_d = idx_q + 1'b1;
        end else begin
          state_d = FSM_NB_SQ;
        end
      end
      FSM_NB_SQ: state_d = FSM_NB_CMP;
      FSM_NB_CMP: begin
        hit = dsum <= {1'b0, rr_q};
        if (hit && pend_v_q && !can_push_i) begin
          state_d = FSM_NB_CMP;
        end else begin
          if (hit) begin
            push_o.valid = pend_v_q;
            pend_d = rdata; pend_v_d = 1'b1;
          end
          if (last_idx) begin
            state_d = FSM_FINISH;
          end else begin
            idx_d = idx_q + 1'b1; state_d = FSM_NB_RD;
          end
        end
      end
      FSM_FINISH: begin
        if (can_push_i) begin
          push_o.valid = 1'b1;
          push_o.last  = 1'b1;
          if (!pend_v_q) begin
            push_o.status = fin_q;
            push_o.entry  = '0;
          end
          pend_v_d = 1'b0;
          state_d  = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* design/point_table_radius_search_top.sv */
// Top level of the point table radius search block: sequencer plus output
// register. Depends on ptrs_pkg and ptrs_ctrl.
//
// Usage: one command request enters on the s_axis channel (command in tuser),
// and the block answers on the m_axis channel with one or more results; the
// final result of a command carries tlast. tuser on the output is the status.
// The table lives in one memory of TABLE_DEPTH entries with a registered read.
// Insert writes the new entry at the end of the table. Find, list and delete
// scan the entries in turn (read, compare); a delete then moves each later
// entry down (read, write). An around-search scans for the center entry, then
// checks every other entry (read, square, compare). One command is in work at
// a time; the next is taken once the last result sits in the output register.
// Reset empties the table (entry count zero); no clearing pass is needed.
// When the receiver stalls, one result waits in the output register and one
// more is held inside; the scan then pauses until the output drains.
`default_nettype none
module point_table_radius_search_top #(
  parameter int unsigned TABLE_DEPTH = ptrs_pkg::TableDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // name_word_high, name_word_mid, name_word_low, x_coord, y_coord, search_radius
  input  wire logic [ptrs_pkg::InDataW-1:0] s_axis_tdata,
  // command
  input  wire logic [2:0]                   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // out_name_high, out_name_mid, out_name_low, out_x, out_y
  output logic [ptrs_pkg::EntryW-1:0]       m_axis_tdata,
  // status
  output logic [1:0]                        m_axis_tuser,
  // last_result
  output logic                              m_axis_tlast
);
  import ptrs_pkg::*;

  ptrs_push_t push;
  logic       can_push;
  logic       out_v_q, out_v_d;

  ptrs_ctrl #(.TableDepth(TABLE_DEPTH)) u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(s_axis_tvalid), .req_ready_o(s_axis_tready),
    .req_cmd_i(s_axis_tuser), .req_data_i(s_axis_tdata),
    .can_push_i(can_push), .push_o(push)
  );

  // output register
  assign can_push = !out_v_q || m_axis_tready;
  assign out_v_d  = push.valid ? 1'b1 : (m_axis_tready ? 1'b0 : out_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else         out_v_q <= out_v_d;
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      m_axis_tdata <= push.entry;
      m_axis_tuser <= push.status;
      m_axis_tlast <= push.last;
    end
  end

  assign m_axis_tvalid = out_v_q;

endmodule
`default_nettype wire
